FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also runs through reset
`define ASSERT_CLK_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/ptts_pkg.sv
package ptts_pkg;

    localparam int unsigned DIV_W     = 20;
    localparam int unsigned DVSR_W    = 16;
    localparam int unsigned DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd20;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_TICK    = 2'd1,
        OP_SUSPEND = 2'd2,
        OP_SLEEP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_SUSPENDED = 2'd0,
        MODE_READY     = 2'd1,
        MODE_SLEEP     = 2'd2,
        MODE_IDLE      = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SLOT,
        S_DIV,
        S_FIN
    } t_state;

    // configuration register indexes
    localparam logic [2:0] CFG_TICK    = 3'd0;
    localparam logic [2:0] CFG_PERIOD0 = 3'd1;
    localparam logic [2:0] CFG_PERIOD1 = 3'd2;
    localparam logic [2:0] CFG_PERIOD2 = 3'd3;
    localparam logic [2:0] CFG_PERIOD3 = 3'd4;
    localparam logic [2:0] CFG_PRESENT = 3'd5;

    typedef struct packed {
        logic [7:0]        tick_ms;
        logic [3:0][15:0]  period;
        logic [3:0]        present;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic set_err;
        logic suspend;
        logic div_start;
        logic apply;
        logic next;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic tick_zero;
        logic sleep_ok;
        logic need_div;
        logic item_last;
        logic div_done;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] sat8(input logic [DIV_W-1:0] v);
        return (|v[DIV_W-1:8]) ? 8'hFF : v[7:0];
    endfunction

endpackage

FILE: hdl/ptts_regs.sv
module ptts_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [2:0]        i_index,
    input  logic [15:0]       i_data,
    output ptts_pkg::t_cfg    o_cfg
);
    import ptts_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_ms <= 8'd1;
            r_cfg.period  <= {4{16'd1000}};
            r_cfg.present <= 4'hF;
        end else if (i_wr) begin
            case (i_index)
                CFG_TICK:    r_cfg.tick_ms <= i_data[7:0];
                CFG_PERIOD0,
                CFG_PERIOD1,
                CFG_PERIOD2,
                CFG_PERIOD3: r_cfg.period[2'(i_index - CFG_PERIOD0)] <= i_data;
                CFG_PRESENT: r_cfg.present <= i_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/ptts_ctrl.sv
module ptts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ptts_pkg::t_stat  i_stat,
    output ptts_pkg::t_cmd   o_cmd,
    output logic             o_idle
);
    import ptts_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_START: begin
                        if (i_stat.tick_zero) begin
                            w_cmd.set_err = 1'b1;
                            n_state       = S_FIN;
                        end else begin
                            n_state = S_SLOT;
                        end
                    end
                    OP_TICK: n_state = S_SLOT;
                    OP_SUSPEND: begin
                        w_cmd.suspend = 1'b1;
                        n_state       = S_FIN;
                    end
                    OP_SLEEP: begin
                        if (i_stat.sleep_ok) begin
                            w_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end else begin
                            w_cmd.set_err = 1'b1;
                            n_state       = S_FIN;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_SLOT: begin
                if (i_stat.need_div) begin
                    w_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    w_cmd.apply = 1'b1;
                    if (i_stat.item_last) begin
                        n_state = S_FIN;
                    end else begin
                        w_cmd.next = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    w_cmd.apply = 1'b1;
                    if (i_stat.item_last) begin
                        n_state = S_FIN;
                    end else begin
                        w_cmd.next = 1'b1;
                        n_state    = S_SLOT;
                    end
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_idle = (r_state == S_IDLE);

`include "assert_macros.svh"

    `ASSERT_CLK(a_emit_only_when_free, w_cmd.emit |-> i_stat.out_free, "result emitted over a full output register")
    `ASSERT_CLK_NR(a_reset_to_idle, !i_rst_n |=> r_state == S_IDLE, "controller not idle after reset")

endmodule

FILE: hdl/ptts_dp.sv
module ptts_dp #(
    parameter int TASKS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptts_pkg::t_cmd   i_cmd,
    input  ptts_pkg::t_cfg   i_cfg,
    input  logic [1:0]       i_operation,
    input  logic [1:0]       i_task_index,
    input  logic [19:0]      i_sleep_period_ms,
    input  logic             i_out_stall,
    output ptts_pkg::t_stat  o_stat,
    output logic             o_out_valid,
    output logic [3:0]       o_run_mask,
    output logic             o_status
);
    import ptts_pkg::*;

    localparam int SW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(TASKS - 1);
    localparam logic [2:0]    TASKS_L   = 3'(TASKS);

    // item latched at accept
    t_op               r_op;
    logic [1:0]        r_idx;
    logic [19:0]       r_req;
    logic [SW-1:0]     r_slot;

    // per slot state
    logic [7:0]        r_cnt   [TASKS];
    t_mode             r_mode  [TASKS];
    logic [7:0]        r_pause [TASKS];

    // shared restoring divider
    logic [DIV_W-1:0]     r_quo;
    logic [DVSR_W-1:0]    r_rem;
    logic [DVSR_W-1:0]    r_dvsr;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [3:0]        r_mask;
    logic              r_status;
    logic              r_out_valid;
    logic [3:0]        r_run_mask;
    logic              r_out_status;

    logic [DVSR_W:0]   w_shift;
    logic [DVSR_W:0]   w_diff;
    logic              w_ge;
    logic [SW-1:0]     w_idx_s;
    logic              w_idx_ok;
    logic [15:0]       w_per_slot;
    logic [15:0]       w_per_idx;
    logic              w_tick_zero;
    logic [DIV_W-1:0]  w_q_tick;
    logic [DIV_W-1:0]  w_q_dec;
    logic [7:0]        w_reload;
    logic [7:0]        w_pause_dec;
    t_stat             w_stat;

    assign w_idx_s     = r_idx[SW-1:0];
    assign w_idx_ok    = ({1'b0, r_idx} < TASKS_L);
    assign w_per_slot  = i_cfg.period[2'(r_slot)];
    assign w_per_idx   = i_cfg.period[r_idx];
    assign w_tick_zero = (i_cfg.tick_ms == 8'd0);

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvsr};
    assign w_ge    = (w_shift >= {1'b0, r_dvsr});

    // reload is quotient minus one, zero tick counts as a zero quotient
    assign w_q_tick    = w_tick_zero ? '0 : r_quo;
    assign w_q_dec     = w_q_tick - DIV_W'(1);
    assign w_reload    = (w_q_tick == '0) ? 8'd0 : sat8(w_q_dec);
    assign w_pause_dec = r_pause[r_slot] - 8'd1;

    always_comb begin
        w_stat.op        = r_op;
        w_stat.tick_zero = w_tick_zero;
        w_stat.sleep_ok  = w_idx_ok && (r_mode[w_idx_s] == MODE_READY) &&
                           (w_per_idx != 16'd0) && (r_req > {4'd0, w_per_idx});
        w_stat.need_div  = (r_op == OP_START) ||
                           ((r_cnt[r_slot] == 8'd0) && !w_tick_zero);
        w_stat.item_last = (r_op == OP_SLEEP) || (r_slot == SLOT_LAST);
        w_stat.div_done  = (r_div_cnt == '0);
        w_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < TASKS; s++) begin
                r_cnt[s]   <= 8'd0;
                r_mode[s]  <= MODE_SUSPENDED;
                r_pause[s] <= 8'd0;
            end
        end else begin
            if (i_cmd.load) begin
                r_slot <= '0;
            end else if (i_cmd.next) begin
                r_slot <= r_slot + SW'(1);
            end

            if (i_cmd.div_start) begin
                r_div_cnt <= DIV_STEPS;
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.suspend && w_idx_ok) begin
                r_mode[w_idx_s] <= MODE_SUSPENDED;
            end

            if (i_cmd.apply) begin
                case (r_op)
                    OP_START: begin
                        r_cnt[r_slot]  <= sat8(r_quo);
                        r_mode[r_slot] <= MODE_READY;
                    end
                    OP_TICK: begin
                        if (r_cnt[r_slot] == 8'd0) begin
                            r_cnt[r_slot] <= w_reload;
                            if (r_mode[r_slot] == MODE_SLEEP) begin
                                r_pause[r_slot] <= w_pause_dec;
                                if (w_pause_dec == 8'd0) begin
                                    r_mode[r_slot] <= MODE_READY;
                                end
                            end
                        end else begin
                            r_cnt[r_slot] <= r_cnt[r_slot] - 8'd1;
                        end
                    end
                    OP_SLEEP: begin
                        r_mode[w_idx_s]  <= MODE_SLEEP;
                        r_pause[w_idx_s] <= sat8(r_quo);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_operation);
            r_idx    <= i_task_index;
            r_req    <= i_sleep_period_ms;
            r_mask   <= 4'd0;
            r_status <= 1'b0;
        end else begin
            if (i_cmd.set_err || (i_cmd.suspend && !w_idx_ok)) begin
                r_status <= 1'b1;
            end
            if (i_cmd.apply && (r_op == OP_TICK) && (r_cnt[r_slot] == 8'd0) &&
                (r_mode[r_slot] == MODE_READY) && i_cfg.present[2'(r_slot)]) begin
                r_mask <= r_mask | (4'd1 << r_slot);
            end
        end

        if (i_cmd.div_start) begin
            r_rem <= '0;
            if (r_op == OP_SLEEP) begin
                r_quo  <= r_req;
                r_dvsr <= w_per_idx;
            end else begin
                r_quo  <= {4'd0, w_per_slot};
                r_dvsr <= {8'd0, i_cfg.tick_ms};
            end
        end else if (r_div_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DVSR_W-1:0] : w_shift[DVSR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end

        if (i_cmd.emit) begin
            r_run_mask   <= r_mask;
            r_out_status <= r_status;
        end
    end

    assign o_stat      = w_stat;
    assign o_out_valid = r_out_valid;
    assign o_run_mask  = r_run_mask;
    assign o_status    = r_out_status;

`include "assert_macros.svh"

    `ASSERT_CLK(a_div_not_busy_on_start, i_cmd.div_start |-> r_div_cnt == '0, "divider restarted while busy")
    `ASSERT_CLK(a_sleep_has_pause, (r_mode[0] == MODE_SLEEP && $past(r_mode[0]) != MODE_SLEEP) |-> r_pause[0] != 8'd0, "slot entered sleep with zero pause")

endmodule

FILE: hdl/periodic_task_tick_scheduler.sv
// accept to o_out_valid: suspend and refused items go straight to the output register; sleep
// divides once, tick walks all slots, dividing for each at zero count (none when tick
// length is zero), start divides per slot; one item at a time through a shared 20-step divider
// throughput: next item accepted the cycle after the result is loaded into the output register
// reset: i_rst_n synchronous active low; slots suspended with zero counts, registers at defaults
module periodic_task_tick_scheduler #(
    parameter int TASKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_task_index,
    input  logic [19:0] i_sleep_period_ms,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_run_mask,
    output logic        o_status,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ptts_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_idle;

    // config writes are always accepted
    assign o_cfg_ready = 1'b1;

    // a transaction is taken only while the controller sits idle; the output
    // register keeps the last result so the next item can start meanwhile
    assign o_in_stall = !w_idle;

    // tick length, slot periods and present mask
    ptts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // sequencer: decode, walk slots, run divider, hand result to output register
    ptts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    // slot state, divider, run mask build-up and output register
    ptts_dp #(
        .TASKS (TASKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg             (w_cfg),
        .i_operation       (i_operation),
        .i_task_index      (i_task_index),
        .i_sleep_period_ms (i_sleep_period_ms),
        .i_out_stall       (i_out_stall),
        .o_stat            (w_stat),
        .o_out_valid       (o_out_valid),
        .o_run_mask        (o_run_mask),
        .o_status          (o_status)
    );

endmodule

FILE: sim/testbench.sv
module testbench;
    import ptts_pkg::*;

    localparam int SLOT_COUNT      = 4;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 135;
    // worst transaction is a start or a tick with every slot dividing
    localparam int SETTLE_CYCLES   = 120;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int MAX_PRINTED     = 200;

    typedef struct packed {
        logic [3:0] run_mask;
        logic       status;
    } t_sched_result;

    // tracks slot state and configuration, predicts the result of every item
    class tick_sched_scoreboard;
        logic [7:0]    tick_ms;
        logic [15:0]   period[4];
        logic [3:0]    present;
        logic [7:0]    countdown[4];
        t_mode         mode[4];
        logic [7:0]    pause[4];
        t_sched_result fire_q[$];
        int            errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            tick_ms = 8'd1;
            present = 4'hF;
            for (int s = 0; s < 4; s++) begin
                period[s]    = 16'd1000;
                countdown[s] = 8'd0;
                mode[s]      = MODE_SUSPENDED;
                pause[s]     = 8'd0;
            end
            fire_q.delete();
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_TICK:    tick_ms = data[7:0];
                CFG_PERIOD0: period[0] = data;
                CFG_PERIOD1: period[1] = data;
                CFG_PERIOD2: period[2] = data;
                CFG_PERIOD3: period[3] = data;
                CFG_PRESENT: present = data[3:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] clamp_byte(logic [19:0] v);
            return (v > 20'd255) ? 8'hFF : v[7:0];
        endfunction

        // period in ticks, zero when the tick length is zero
        function logic [15:0] ticks_per_period(int s);
            if (tick_ms == 8'd0) begin
                return 16'd0;
            end
            return period[s] / {8'd0, tick_ms};
        endfunction

        function void predict_item(t_op op, logic [1:0] slot, logic [19:0] req);
            t_sched_result r;
            logic [15:0]   q;
            logic [15:0]   per;
            r = '0;
            case (op)
                OP_START: begin
                    if (tick_ms == 8'd0) begin
                        r.status = 1'b1;
                    end else begin
                        for (int s = 0; s < SLOT_COUNT; s++) begin
                            countdown[s] = clamp_byte({4'd0, ticks_per_period(s)});
                            mode[s]      = MODE_READY;
                        end
                    end
                end
                OP_TICK: begin
                    for (int s = 0; s < SLOT_COUNT; s++) begin
                        if (countdown[s] == 8'd0) begin
                            q = ticks_per_period(s);
                            if (mode[s] == MODE_READY) begin
                                if (present[s]) begin
                                    r.run_mask[s] = 1'b1;
                                end
                            end else if (mode[s] == MODE_SLEEP) begin
                                pause[s] = pause[s] - 8'd1;
                                if (pause[s] == 8'd0) begin
                                    mode[s] = MODE_READY;
                                end
                            end
                            countdown[s] = (q == 16'd0) ? 8'd0 :
                                           clamp_byte({4'd0, q - 16'd1});
                        end else begin
                            countdown[s] = countdown[s] - 8'd1;
                        end
                    end
                end
                OP_SUSPEND: begin
                    if (int'(slot) < SLOT_COUNT) begin
                        mode[slot] = MODE_SUSPENDED;
                    end else begin
                        r.status = 1'b1;
                    end
                end
                default: begin
                    per = period[slot];
                    if (int'(slot) < SLOT_COUNT && mode[slot] == MODE_READY &&
                        per != 16'd0 && req > {4'd0, per}) begin
                        mode[slot]  = MODE_SLEEP;
                        pause[slot] = clamp_byte(req / {4'd0, per});
                    end else begin
                        r.status = 1'b1;
                    end
                end
            endcase
            fire_q.push_back(r);
        endfunction

        function int pending();
            return fire_q.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_result(logic [3:0] mask, logic status);
            t_sched_result exp_r;
            if (fire_q.size() == 0) begin
                report($sformatf("unexpected result mask %h status %b", mask, status));
            end else begin
                exp_r = fire_q.pop_front();
                if (mask !== exp_r.run_mask) begin
                    report($sformatf("run_mask %h, expected %h", mask, exp_r.run_mask));
                end
                if (status !== exp_r.status) begin
                    report($sformatf("status %b, expected %b", status, exp_r.status));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [1:0]  i_task_index;
    logic [19:0] i_sleep_period_ms;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_run_mask;
    logic        o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // idling knobs, percent per cycle
    int send_idle_pct;
    int recv_stall_pct;
    // nonzero asks the result side for one long hold-off
    int holdoff_req;

    tick_sched_scoreboard sched_sb = new();

    periodic_task_tick_scheduler #(
        .TASKS(SLOT_COUNT)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_task_index     (i_task_index),
        .i_sleep_period_ms(i_sleep_period_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_run_mask       (o_run_mask),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stall, or one long hold-off when asked
    initial begin
        int hold_n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_req > 0) begin
                hold_n      = holdoff_req;
                holdoff_req = 0;
                i_out_stall <= 1'b1;
                repeat (hold_n - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sched_sb.check_result(o_run_mask, o_status);
        end
    end

    // optional gap after an accepted item; valid drops here only when a gap is taken
    task idle_gap();
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task send_item(t_op op, logic [1:0] slot, logic [19:0] req);
        i_in_valid        <= 1'b1;
        i_operation       <= op;
        i_task_index      <= slot;
        i_sleep_period_ms <= req;
        do @(posedge i_clk); while (o_in_stall);
        sched_sb.predict_item(op, slot, req);
        idle_gap();
    endtask

    // stop offering items until every predicted result has come back
    task drain();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (sched_sb.pending() != 0 && n < DRAIN_LIMIT);
    endtask

    task cfg_write(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sched_sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // per-phase settings, extremes on fixed phases, mostly short periods otherwise
    task random_config(int p);
        int tick;
        int teff;
        int per;
        if (p == 1) begin
            tick = 255;
        end else if (p == 2) begin
            tick = 1;
        end else if (p == 5) begin
            tick = 0;
        end else begin
            tick = $urandom_range(1, 40);
        end
        teff = (tick == 0) ? 1 : tick;
        cfg_write(CFG_TICK, 16'(tick));
        for (int s = 0; s < 4; s++) begin
            if (p == 3) begin
                // zero, minimum and maximum period in one setting
                per = (s == 0) ? 0 : (s == 1) ? 1 : (s == 2) ? 65535 : $urandom_range(65535);
            end else if ($urandom_range(7) == 0) begin
                per = $urandom_range(65535);
            end else begin
                per = teff * $urandom_range(0, 4) + $urandom_range(0, teff - 1);
                if (per == 0) begin
                    per = 1;
                end
            end
            if (per > 65535) begin
                per = 65535;
            end
            cfg_write(3'(int'(CFG_PERIOD0) + s), 16'(per));
        end
        if (p == 0) begin
            cfg_write(CFG_PRESENT, 16'hF);
        end else if (p == 4) begin
            cfg_write(CFG_PRESENT, 16'h0);
        end else begin
            cfg_write(CFG_PRESENT, 16'($urandom_range(15)));
        end
    endtask

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 7) begin
            return OP_START;
        end else if (r < 72) begin
            return OP_TICK;
        end else if (r < 78) begin
            return OP_SUSPEND;
        end
        return OP_SLEEP;
    endfunction

    // sleep length: mostly a few periods, some at the period boundary, some anywhere
    function automatic logic [19:0] sleep_request(logic [1:0] slot);
        int per;
        int r;
        int req;
        per = sched_sb.period[slot];
        r   = $urandom_range(99);
        if (r < 60) begin
            req = per + $urandom_range(1, 3 * per + 1);
        end else if (r < 75) begin
            req = per + $urandom_range(0, 2) - 1;
        end else begin
            req = $urandom_range(20'hFFFFF);
        end
        if (req < 0) begin
            req = 0;
        end else if (req > 20'hFFFFF) begin
            req = 20'hFFFFF;
        end
        return 20'(req);
    endfunction

    initial begin
        t_op        op;
        logic [1:0] slot;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 0;

        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_operation       <= OP_START;
        i_task_index      <= 2'd0;
        i_sleep_period_ms <= 20'd0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= CFG_TICK;
        i_cfg_data        <= 16'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, default settings: periods saturate the countdown
        send_item(OP_TICK, 2'd0, 20'd0);          // all slots suspended
        send_item(OP_SLEEP, 2'd0, 20'd1001);      // sleep refused, slot suspended
        send_item(OP_START, 2'd0, 20'd0);
        send_item(OP_TICK, 2'd1, 20'hFFFFF);
        send_item(OP_SLEEP, 2'd0, 20'd0);         // request below period
        send_item(OP_SLEEP, 2'd0, 20'd1000);      // request equal to period
        send_item(OP_SLEEP, 2'd0, 20'd1001);      // one period of pause
        send_item(OP_SLEEP, 2'd0, 20'd5000);      // already asleep
        send_item(OP_SLEEP, 2'd1, 20'hFFFFF);     // pause saturates
        send_item(OP_SUSPEND, 2'd2, 20'd0);
        send_item(OP_SUSPEND, 2'd3, 20'hFFFFF);
        send_item(OP_TICK, 2'd3, 20'd0);
        drain();

        // zero period, quotient zero, saturated and short countdowns, absent tasks
        cfg_write(CFG_TICK, 16'd255);
        cfg_write(CFG_PERIOD0, 16'd0);
        cfg_write(CFG_PERIOD1, 16'd1);
        cfg_write(CFG_PERIOD2, 16'hFFFF);
        cfg_write(CFG_PERIOD3, 16'd300);
        cfg_write(CFG_PRESENT, 16'b0101);
        cfg_write(3'd6, 16'hFFFF);                // unknown indexes are ignored
        cfg_write(3'd7, 16'h0000);
        send_item(OP_START, 2'd0, 20'd0);
        send_item(OP_TICK, 2'd0, 20'd0);
        send_item(OP_SLEEP, 2'd0, 20'd5);         // zero period refuses sleep
        send_item(OP_SLEEP, 2'd3, 20'd301);
        send_item(OP_TICK, 2'd0, 20'd0);
        send_item(OP_TICK, 2'd0, 20'd0);
        send_item(OP_TICK, 2'd0, 20'd0);
        drain();

        // zero tick length: start fails, ticks reload zero
        cfg_write(CFG_TICK, 16'd0);
        send_item(OP_START, 2'd0, 20'd0);
        send_item(OP_TICK, 2'd0, 20'd0);
        send_item(OP_SUSPEND, 2'd1, 20'd0);
        send_item(OP_TICK, 2'd0, 20'd0);

        // random part: each phase starts the scheduler then mostly ticks
        for (int p = 0; p < PHASES; p++) begin
            drain();
            random_config(p);
            send_idle_pct  = (p % 4 == 1) ? 58 : (p % 4 == 3) ? 21 : 0;
            recv_stall_pct = (p % 4 == 2) ? 58 : (p % 4 == 3) ? 21 : 0;
            send_item(OP_START, 2'($urandom_range(3)), 20'($urandom_range(20'hFFFFF)));
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // result side holds off while items keep coming, so the block backs up
                if (p == 2 && i == 30) begin
                    holdoff_req = HOLDOFF_CYCLES;
                end
                // sender waits for the block to empty in mid-phase
                if (p == 6 && i == 60) begin
                    drain();
                end
                op   = pick_op();
                slot = 2'($urandom_range(3));
                if (op == OP_SLEEP) begin
                    send_item(op, slot, sleep_request(slot));
                end else begin
                    send_item(op, slot, 20'($urandom_range(20'hFFFFF)));
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sched_sb.pending() != 0) begin
            sched_sb.report($sformatf("%0d results never arrived", sched_sb.pending()));
        end
        if (sched_sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ptts_pkg.sv
hdl/ptts_regs.sv
hdl/ptts_ctrl.sv
hdl/ptts_dp.sv
hdl/periodic_task_tick_scheduler.sv
sim/testbench.sv
